// ===== src/tmvg_pkg.sv =====
// Shared types, constants and coefficients for the torus mesh vertex generator.
`default_nettype none
package tmvg_pkg;

  localparam int ANGLE_BITS_DEF  = 16;
  localparam int MAX_SAMPLES_DEF = 1024;

  localparam int IDX_W    = 10;
  localparam int CNT_W    = 11;
  localparam int RAD_W    = 16;
  localparam int TRIG_W   = 16;
  localparam int POS_W    = 18;
  localparam int CORNER_W = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [RAD_W-1:0] MAJOR_RESET = 16'd512;
  localparam logic [RAD_W-1:0] MINOR_RESET = 16'd256;
  localparam logic [CNT_W-1:0] RING_RESET  = 11'd32;
  localparam logic [CNT_W-1:0] TUBE_RESET  = 11'd16;

  localparam logic signed [32:0] SIN_COEF [5] = '{
    33'sd1686629713,
    -33'sd693598668,
    33'sd85569306,
    -33'sd5026995,
    33'sd172273
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAJOR_RADIUS = 2'd0,
    CFG_MINOR_RADIUS = 2'd1,
    CFG_RING_COUNT   = 2'd2,
    CFG_TUBE_COUNT   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                err;
    logic [CORNER_W-1:0] here;
    logic [CORNER_W-1:0] next_tube;
    logic [CORNER_W-1:0] next_ring;
    logic [CORNER_W-1:0] next_ring_prev_tube;
  } side_t;

endpackage
`default_nettype wire

// ===== src/torus_mesh_vertex_generator_core.sv =====
// Throughput: one grid point per cycle; busy is never asserted.
// The phase divider contributes ANGLE_BITS stages, the sine pipeline 8 and position 3.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset restores the register defaults and drops all items in flight.
`default_nettype none
module torus_mesh_vertex_generator_core
  import tmvg_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int ANGLE_BITS  = ANGLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [IDX_W-1:0]      in_ring_index,
  input  wire logic [IDX_W-1:0]      in_tube_index,
  output logic                       out_valid,
  output logic signed [POS_W-1:0]    out_pos_x,
  output logic signed [POS_W-1:0]    out_pos_y,
  output logic signed [POS_W-1:0]    out_pos_z,
  output logic [CORNER_W-1:0]        out_corner_here,
  output logic [CORNER_W-1:0]        out_corner_next_tube,
  output logic [CORNER_W-1:0]        out_corner_next_ring,
  output logic [CORNER_W-1:0]        out_corner_next_ring_prev_tube,
  output logic                       out_index_error,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FB  = ANGLE_BITS - 2;
  localparam int LAT = ANGLE_BITS + 11;

  logic [RAD_W-1:0] major_r, minor_r;
  logic [CNT_W-1:0] ring_cnt_r, tube_cnt_r;
  logic             accept;
  logic [LAT-1:0]   vld_r;
  side_t            side_q;
  side_t            side_r [1:LAT-1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      major_r    <= MAJOR_RESET;
      minor_r    <= MINOR_RESET;
      ring_cnt_r <= RING_RESET;
      tube_cnt_r <= TUBE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MAJOR_RADIUS: major_r    <= cfg_data;
        CFG_MINOR_RADIUS: minor_r    <= cfg_data;
        CFG_RING_COUNT:   ring_cnt_r <= cfg_data[CNT_W-1:0];
        CFG_TUBE_COUNT:   tube_cnt_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  tmvg_corner #(.MAX_SAMPLES(MAX_SAMPLES)) u_corner (
    .clk        (clk),
    .ring       (in_ring_index),
    .tube       (in_tube_index),
    .ring_count (ring_cnt_r),
    .tube_count (tube_cnt_r),
    .side       (side_q)
  );

  always_ff @(posedge clk) begin
    side_r[1] <= side_q;
    for (int k = 2; k < LAT; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  logic [ANGLE_BITS-1:0] rphase, tphase, rphase_q, tphase_q;
  localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {FB{1'b0}}};

  tmvg_phase_div #(.ANGLE_BITS(ANGLE_BITS)) u_ring_div (
    .clk (clk), .idx (in_ring_index), .cnt (ring_cnt_r), .phase (rphase)
  );

  tmvg_phase_div #(.ANGLE_BITS(ANGLE_BITS)) u_tube_div (
    .clk (clk), .idx (in_tube_index), .cnt (tube_cnt_r), .phase (tphase)
  );

  assign rphase_q = rphase + QUARTER;
  assign tphase_q = tphase + QUARTER;

  logic signed [TRIG_W-1:0] sr, cr, st, ct;

  tmvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_ring (
    .clk (clk), .phase (rphase), .sine (sr)
  );

  tmvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_ring (
    .clk (clk), .phase (rphase_q), .sine (cr)
  );

  tmvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_tube (
    .clk (clk), .phase (tphase), .sine (st)
  );

  tmvg_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_tube (
    .clk (clk), .phase (tphase_q), .sine (ct)
  );

  logic signed [POS_W-1:0] px, py, pz;

  tmvg_position u_position (
    .clk          (clk),
    .major_radius (major_r),
    .minor_radius (minor_r),
    .sin_ring     (sr),
    .cos_ring     (cr),
    .sin_tube     (st),
    .cos_tube     (ct),
    .pos_x        (px),
    .pos_y        (py),
    .pos_z        (pz)
  );

  side_t side_o;
  assign side_o = side_r[LAT-1];

  assign out_valid                      = vld_r[LAT-1];
  assign out_index_error                = side_o.err;
  assign out_pos_x                      = side_o.err ? '0 : px;
  assign out_pos_y                      = side_o.err ? '0 : py;
  assign out_pos_z                      = side_o.err ? '0 : pz;
  assign out_corner_here                = side_o.err ? '0 : side_o.here;
  assign out_corner_next_tube           = side_o.err ? '0 : side_o.next_tube;
  assign out_corner_next_ring           = side_o.err ? '0 : side_o.next_ring;
  assign out_corner_next_ring_prev_tube = side_o.err ? '0 : side_o.next_ring_prev_tube;

`ifndef SYNTHESIS
  a_z_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_index_error |->
      ($signed(out_pos_z) <= $signed({2'b00, minor_r})) &&
      ($signed(out_pos_z) >= -$signed({2'b00, minor_r})))
    else $error("pos_z exceeds the minor radius");

  a_next_tube: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_index_error |->
      (out_corner_next_tube == CORNER_W'(out_corner_here + 20'd1)) ||
      (CORNER_W'(out_corner_next_tube + 20'(tube_cnt_r) - 20'd1) == out_corner_here))
    else $error("next tube corner is not adjacent");

  a_prev_tube: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_index_error |->
      (out_corner_next_ring_prev_tube == CORNER_W'(out_corner_next_ring - 20'd1)) ||
      (out_corner_next_ring_prev_tube ==
        CORNER_W'(out_corner_next_ring + 20'(tube_cnt_r) - 20'd1)))
    else $error("previous tube corner is not adjacent");
`endif

endmodule
`default_nettype wire

// ===== src/tmvg_phase_div.sv =====
// Pipelined restoring divider that turns a sample index into an angle phase.
`default_nettype none
module tmvg_phase_div
  import tmvg_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic [IDX_W-1:0]      idx,
  input  wire logic [CNT_W-1:0]      cnt,
  output logic      [ANGLE_BITS-1:0] phase
);

  logic [CNT_W-1:0]      rem_r [ANGLE_BITS];
  logic [ANGLE_BITS-1:0] quo_r [ANGLE_BITS];

  genvar k;
  generate
    for (k = 0; k < ANGLE_BITS; k++) begin : g_step
      logic [CNT_W-1:0]      rem_in;
      logic [ANGLE_BITS-1:0] quo_in;
      logic [CNT_W:0]        trial;
      logic                  take;
      if (k == 0) begin : g_first
        assign rem_in = {1'b0, idx};
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign quo_in = quo_r[k-1];
      end
      assign trial = {rem_in, 1'b0};
      assign take  = (trial >= {1'b0, cnt});
      always_ff @(posedge clk) begin
        rem_r[k] <= take ? CNT_W'(trial - {1'b0, cnt}) : trial[CNT_W-1:0];
        quo_r[k] <= {quo_in[ANGLE_BITS-2:0], take};
      end
    end
  endgenerate

  assign phase = quo_r[ANGLE_BITS-1];

endmodule
`default_nettype wire

// ===== src/tmvg_sine.sv =====
// Pipelined fixed-point sine of a phase by an odd polynomial in Horner form.
`default_nettype none
module tmvg_sine
  import tmvg_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic [ANGLE_BITS-1:0]    phase,
  output logic signed [TRIG_W-1:0]      sine
);

  localparam int FB = ANGLE_BITS - 2;

  logic [FB:0]             zf_r;
  logic                    neg_r [6];
  logic [30:0]             z_r   [5];
  logic [30:0]             z2_r  [4];
  logic signed [32:0]      p_r   [4];
  logic signed [32:0]      q_r;
  logic signed [TRIG_W-1:0] s_r;

  logic [FB-1:0] frac;
  logic [FB:0]   zf_nxt;
  logic [30:0]   z_full;
  logic [61:0]   zz;

  assign frac   = phase[FB-1:0];
  assign zf_nxt = phase[FB] ? ({1'b1, {FB{1'b0}}} - {1'b0, frac}) : {1'b0, frac};
  assign z_full = {zf_r, {(30 - FB){1'b0}}};
  assign zz     = z_full * z_full;

  always_ff @(posedge clk) begin
    zf_r     <= zf_nxt;
    neg_r[0] <= phase[FB+1];
    z_r[0]   <= z_full;
    z2_r[0]  <= zz[60:30];
    neg_r[1] <= neg_r[0];
  end

  genvar k;
  generate
    for (k = 0; k < 4; k++) begin : g_horner
      logic signed [32:0] p_in;
      logic signed [64:0] prod;
      if (k == 0) begin : g_first
        assign p_in = SIN_COEF[4];
      end else begin : g_next
        assign p_in = p_r[k-1];
      end
      assign prod = p_in * $signed({1'b0, z2_r[k]});
      always_ff @(posedge clk) begin
        p_r[k]     <= SIN_COEF[3-k] + $signed(prod[62:30]);
        z_r[k+1]   <= z_r[k];
        neg_r[k+2] <= neg_r[k+1];
      end
      if (k < 3) begin : g_z2
        always_ff @(posedge clk) begin
          z2_r[k+1] <= z2_r[k];
        end
      end
    end
  endgenerate

  logic signed [64:0] fprod;
  logic signed [33:0] rnd;
  logic signed [18:0] s_val;
  logic signed [TRIG_W-1:0] s_clamp;
  logic               neg_q_r;

  assign fprod = p_r[3] * $signed({1'b0, z_r[4]});
  assign rnd   = 34'(q_r) + 34'sd16384;
  assign s_val = rnd[33:15];

  always_comb begin
    if (s_val < 0) begin
      s_clamp = '0;
    end else if (s_val > 19'sd32767) begin
      s_clamp = 16'sd32767;
    end else begin
      s_clamp = s_val[TRIG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    q_r     <= $signed(fprod[62:30]);
    neg_q_r <= neg_r[5];
    s_r     <= neg_q_r ? -s_clamp : s_clamp;
  end

  assign sine = s_r;

endmodule
`default_nettype wire

// ===== src/tmvg_position.sv =====
// Three-stage torus position datapath from radii and ring and tube trig values.
`default_nettype none
module tmvg_position
  import tmvg_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic [RAD_W-1:0]         major_radius,
  input  wire logic [RAD_W-1:0]         minor_radius,
  input  wire logic signed [TRIG_W-1:0] sin_ring,
  input  wire logic signed [TRIG_W-1:0] cos_ring,
  input  wire logic signed [TRIG_W-1:0] sin_tube,
  input  wire logic signed [TRIG_W-1:0] cos_tube,
  output logic signed [POS_W-1:0]       pos_x,
  output logic signed [POS_W-1:0]       pos_y,
  output logic signed [POS_W-1:0]       pos_z
);

  function automatic logic signed [POS_W-1:0] sat(input logic signed [19:0] v);
    if (v > 20'sd131071) begin
      return 18'sd131071;
    end else if (v < -20'sd131072) begin
      return -18'sd131072;
    end else begin
      return v[POS_W-1:0];
    end
  endfunction

  logic signed [33:0]       rad_r;
  logic signed [32:0]       zp_r;
  logic signed [TRIG_W-1:0] cr_r, sr_r;
  logic signed [19:0]       x_r, y_r, z_r;
  logic signed [POS_W-1:0]  px_r, py_r, pz_r;

  logic signed [32:0] rct;
  logic signed [49:0] xs, ys;
  logic signed [33:0] zs;

  assign rct = $signed({1'b0, minor_radius}) * cos_tube;
  assign xs  = rad_r * cr_r + 50'sd536870912;
  assign ys  = rad_r * sr_r + 50'sd536870912;
  assign zs  = 34'(zp_r) + 34'sd16384;

  always_ff @(posedge clk) begin
    rad_r <= $signed({3'b000, major_radius, 15'd0}) + 34'(rct);
    zp_r  <= $signed({1'b0, minor_radius}) * sin_tube;
    cr_r  <= cos_ring;
    sr_r  <= sin_ring;
    x_r   <= xs[49:30];
    y_r   <= ys[49:30];
    z_r   <= 20'($signed(zs[33:15]));
    px_r  <= sat(x_r);
    py_r  <= sat(y_r);
    pz_r  <= sat(z_r);
  end

  assign pos_x = px_r;
  assign pos_y = py_r;
  assign pos_z = pz_r;

endmodule
`default_nettype wire

// ===== src/tmvg_corner.sv =====
// Range check and wrapped corner indices of one grid point, registered.
`default_nettype none
module tmvg_corner
  import tmvg_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic             clk,
  input  wire logic [IDX_W-1:0] ring,
  input  wire logic [IDX_W-1:0] tube,
  input  wire logic [CNT_W-1:0] ring_count,
  input  wire logic [CNT_W-1:0] tube_count,
  output side_t                 side
);

  side_t            side_r;
  logic [CNT_W-1:0] ring1, tube1, nring, ntube, ptube;
  logic             err;
  logic [21:0]      base, nbase;

  assign ring1 = {1'b0, ring} + 11'd1;
  assign tube1 = {1'b0, tube} + 11'd1;
  assign nring = (ring1 == ring_count) ? '0 : ring1;
  assign ntube = (tube1 == tube_count) ? '0 : tube1;
  assign ptube = (tube == '0) ? (tube_count - 11'd1) : ({1'b0, tube} - 11'd1);
  assign base  = 22'(ring) * 22'(tube_count);
  assign nbase = 22'(nring) * 22'(tube_count);

  assign err = (ring_count == '0) || (tube_count == '0) ||
               (32'(ring_count) > 32'(MAX_SAMPLES)) ||
               (32'(tube_count) > 32'(MAX_SAMPLES)) ||
               ({1'b0, ring} >= ring_count) || ({1'b0, tube} >= tube_count);

  always_ff @(posedge clk) begin
    side_r.err                 <= err;
    side_r.here                <= CORNER_W'(base + 22'(tube));
    side_r.next_tube           <= CORNER_W'(base + 22'(ntube));
    side_r.next_ring           <= CORNER_W'(nbase + 22'(tube));
    side_r.next_ring_prev_tube <= CORNER_W'(nbase + 22'(ptube));
  end

  assign side = side_r;

endmodule
`default_nettype wire
